// File: hw/rtl/lsv_pkg.sv
package lsv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // quotient bits resolved per divider pipeline stage
  localparam int DIV_STEP = 3;

  typedef logic [1:0] row_t;

  localparam row_t ROW0     = 2'd0;
  localparam row_t ROW1     = 2'd1;
  localparam row_t ROW2     = 2'd2;
  localparam row_t LAST_ROW = ROW2;

endpackage

// File: hw/rtl/lsv_in_if.sv
interface lsv_in_if #(
  parameter int DATA_WIDTH = lsv_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] m00;
  logic signed [DATA_WIDTH-1:0] m01;
  logic signed [DATA_WIDTH-1:0] m02;
  logic signed [DATA_WIDTH-1:0] m10;
  logic signed [DATA_WIDTH-1:0] m11;
  logic signed [DATA_WIDTH-1:0] m12;
  logic signed [DATA_WIDTH-1:0] m20;
  logic signed [DATA_WIDTH-1:0] m21;
  logic signed [DATA_WIDTH-1:0] m22;
  logic signed [DATA_WIDTH-1:0] rhs0;
  logic signed [DATA_WIDTH-1:0] rhs1;
  logic signed [DATA_WIDTH-1:0] rhs2;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, rhs0, rhs1, rhs2,
    input  ready
  );

  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, rhs0, rhs1, rhs2,
    output ready
  );
endinterface

// File: hw/rtl/lsv_out_if.sv
interface lsv_out_if #(
  parameter int DATA_WIDTH = lsv_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  lsv_pkg::row_t                row_index;
  logic signed [DATA_WIDTH-1:0] inv_col0;
  logic signed [DATA_WIDTH-1:0] inv_col1;
  logic signed [DATA_WIDTH-1:0] inv_col2;
  logic signed [DATA_WIDTH-1:0] solution;
  logic                         singular;
  logic                         last_row;

  modport source (
    output valid, row_index, inv_col0, inv_col1, inv_col2, solution, singular, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_index, inv_col0, inv_col1, inv_col2, solution, singular, last_row,
    output ready
  );
endinterface

// File: hw/rtl/lsv_divider.sv
module lsv_divider #(
  parameter int DATA_WIDTH = lsv_pkg::DATA_WIDTH_DEF,
  parameter int NUM_W      = 2 * lsv_pkg::DATA_WIDTH_DEF + 1 + 2 * lsv_pkg::FRAC_BITS_DEF,
  parameter int DEN_W      = 3 * lsv_pkg::DATA_WIDTH_DEF + 3,
  parameter int STEP       = lsv_pkg::DIV_STEP
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_W-1:0]             num_mag,
  input  logic [DEN_W-1:0]             den_mag,
  input  logic                         neg,
  output logic signed [DATA_WIDTH-1:0] quo
);
  localparam int QB   = DATA_WIDTH + 1;
  localparam int NSTG = (QB + STEP - 1) / STEP;
  localparam int CW   = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  typedef logic [CW-1:0] wide_t;
  typedef logic [QB-1:0] qmag_t;

  localparam qmag_t POS_LIM = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam qmag_t NEG_LIM = {2'b01, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  wide_t rem_r [NSTG];
  wide_t den_r [NSTG];
  qmag_t q_r   [NSTG+1];
  logic  neg_r [NSTG+1];
  logic  ovf_r [NSTG+1];

  logic signed [DATA_WIDTH-1:0] quo_r;
  logic signed [DATA_WIDTH-1:0] quo_nxt;

  // quotient wider than QB bits saturates in any case
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= wide_t'(num_mag);
      den_r[0] <= wide_t'(den_mag);
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= wide_t'(num_mag) >= (wide_t'(den_mag) << QB);
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    wide_t rem_c;
    qmag_t q_c;

    // restoring steps, most significant quotient bit first
    always_comb begin
      rem_c = rem_r[s];
      q_c   = q_r[s];
      for (int t = 0; t < STEP; t++) begin
        int b;
        b = QB - 1 - (s * STEP + t);
        if (b >= 0) begin
          if (rem_c >= (den_r[s] << b)) begin
            rem_c  = rem_c - (den_r[s] << b);
            q_c[b] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1]   <= q_c;
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end

    if (s < NSTG - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_c;
          den_r[s+1] <= den_r[s];
        end
      end
    end
  end

  always_comb begin
    if (neg_r[NSTG]) begin
      if (ovf_r[NSTG] || q_r[NSTG] > NEG_LIM) begin
        quo_nxt = Q_MIN;
      end else begin
        quo_nxt = -$signed(q_r[NSTG][DATA_WIDTH-1:0]);
      end
    end else begin
      if (ovf_r[NSTG] || q_r[NSTG] > POS_LIM) begin
        quo_nxt = Q_MAX;
      end else begin
        quo_nxt = $signed(q_r[NSTG][DATA_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

// File: hw/rtl/linear_solve_3x3_unit.sv
// 3x3 inverse and linear solve in signed fixed point (Q16.16 by default). Each accepted
// transaction on in_ch carries a matrix and a right-hand vector and yields three transactions
// on out_ch, rows 0, 1, 2 in order, each with that row of the inverse (adjugate over
// determinant, truncated toward zero, saturated) and the matching solution component; a zero
// determinant sets singular and zeroes every value. Rows are issued from an input holding
// register one per cycle while out_ch is not stalled, into a single pipeline that recomputes
// the cofactors for each row; the next item is accepted as the last row of the held one issues.
// Most of the pipeline depth is in the pipelined restoring divider, three lanes of which run
// side by side, one per inverse column. A stall on out_ch freezes the whole pipeline.
module linear_solve_3x3_unit #(
  parameter int DATA_WIDTH = lsv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = lsv_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lsv_in_if.sink    in_ch,
  lsv_out_if.source out_ch
);
  import lsv_pkg::*;

  localparam int D      = DATA_WIDTH;
  localparam int PW     = 2 * D;
  localparam int PPW    = 2 * D + 1;
  localparam int ADJ_W  = 2 * D + 1;
  localparam int DET_W  = 3 * D + 3;
  localparam int NUM_W  = ADJ_W + 2 * FRAC_BITS;
  localparam int AW     = 2 * D + 2;
  localparam int QB     = D + 1;
  localparam int NSTG   = (QB + DIV_STEP - 1) / DIV_STEP;
  localparam int NSB    = NSTG + 11;
  localparam int IX_S6  = 5;
  localparam int IX_DIV = NSTG + 7;
  localparam int IX_P2  = NSTG + 9;
  localparam int IX_OUT = NSB - 1;

  typedef logic signed [D-1:0]     dat_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic signed [PPW-1:0]   pp_t;
  typedef logic signed [ADJ_W-1:0] adj_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic signed [AW-1:0]    acc_t;

  localparam acc_t SOL_MAX = acc_t'({1'b0, {(D-1){1'b1}}});
  localparam acc_t SOL_MIN = -SOL_MAX - acc_t'(1);
  localparam acc_t RND     = acc_t'({FRAC_BITS{1'b1}});

  logic adv;

  // input holding register, issues one row per cycle unless out_ch stalls
  dat_t hm_r [3][3];
  dat_t hb_r [3];
  logic hold_vld_r;
  row_t row_cnt_r;

  // sideband that travels with every row
  logic vld_r  [NSB];
  row_t row_r  [NSB];
  dat_t rhs_r  [NSB][3];
  logic sing_r [NSB];

  dat_t  c     [3][3];
  prod_t pa    [3];
  prod_t pb    [3];
  prod_t qa    [3];
  prod_t qb    [3];

  prod_t s1_pa_r [3];
  prod_t s1_pb_r [3];
  prod_t s1_qa_r [3];
  prod_t s1_qb_r [3];
  dat_t  s1_m0_r [3];
  adj_t  s2_adj_r  [3];
  adj_t  s2_adj0_r [3];
  dat_t  s2_m0_r   [3];
  pp_t   s3_plo_r [3];
  pp_t   s3_phi_r [3];
  adj_t  s3_adj_r [3];
  det_t  s4_term_r [3];
  adj_t  s4_adj_r  [3];
  det_t  s5_det_r;
  adj_t  s5_adj_r [3];
  logic [NUM_W-1:0] s6_num_r [3];
  logic [DET_W-1:0] s6_den_r;
  logic             s6_neg_r [3];

  dat_t  dq       [3];
  dat_t  inv_z    [3];
  dat_t  p1_inv_r [3];
  prod_t p1_prod_r[3];
  dat_t  p2_inv_r [3];
  acc_t  p2_acc_r;
  dat_t  out_inv_r[3];
  dat_t  out_sol_r;

  logic [ADJ_W-1:0] adj_mag [3];
  logic [DET_W-1:0] det_mag;
  acc_t             acc_biased;
  acc_t             acc_sh;
  dat_t             sol_nxt;

  assign adv         = !vld_r[IX_OUT] || out_ch.ready;
  assign in_ch.ready = !hold_vld_r || (adv && row_cnt_r == LAST_ROW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      row_cnt_r  <= ROW0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_vld_r <= 1'b1;
      row_cnt_r  <= ROW0;
    end else if (adv && hold_vld_r) begin
      if (row_cnt_r == LAST_ROW) begin
        hold_vld_r <= 1'b0;
        row_cnt_r  <= ROW0;
      end else begin
        row_cnt_r  <= row_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hm_r[0][0] <= in_ch.m00;
      hm_r[0][1] <= in_ch.m01;
      hm_r[0][2] <= in_ch.m02;
      hm_r[1][0] <= in_ch.m10;
      hm_r[1][1] <= in_ch.m11;
      hm_r[1][2] <= in_ch.m12;
      hm_r[2][0] <= in_ch.m20;
      hm_r[2][1] <= in_ch.m21;
      hm_r[2][2] <= in_ch.m22;
      hb_r[0]    <= in_ch.rhs0;
      hb_r[1]    <= in_ch.rhs1;
      hb_r[2]    <= in_ch.rhs2;
    end
  end

  // rotate columns so that row i of the adjugate uses the row 0 formula
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      case (row_cnt_r)
        ROW1: begin
          c[r][0] = hm_r[r][1];
          c[r][1] = hm_r[r][2];
          c[r][2] = hm_r[r][0];
        end
        ROW2: begin
          c[r][0] = hm_r[r][2];
          c[r][1] = hm_r[r][0];
          c[r][2] = hm_r[r][1];
        end
        ROW0: begin
          c[r] = hm_r[r];
        end
        default: begin
          c[r] = hm_r[r];
        end
      endcase
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_col
    localparam int J1 = (j + 1) % 3;
    localparam int J2 = (j + 2) % 3;

    assign pa[j] = prod_t'(c[J1][1]) * prod_t'(c[J2][2]);
    assign pb[j] = prod_t'(c[J1][2]) * prod_t'(c[J2][1]);
    assign qa[j] = prod_t'(hm_r[J1][1]) * prod_t'(hm_r[J2][2]);
    assign qb[j] = prod_t'(hm_r[J1][2]) * prod_t'(hm_r[J2][1]);

    assign adj_mag[j] = s5_adj_r[j][ADJ_W-1] ? ADJ_W'(-s5_adj_r[j]) : ADJ_W'(s5_adj_r[j]);
    assign inv_z[j]   = sing_r[IX_DIV] ? '0 : dq[j];

    lsv_divider #(
      .DATA_WIDTH (D),
      .NUM_W      (NUM_W),
      .DEN_W      (DET_W),
      .STEP       (DIV_STEP)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .num_mag (s6_num_r[j]),
      .den_mag (s6_den_r),
      .neg     (s6_neg_r[j]),
      .quo     (dq[j])
    );
  end

  assign det_mag = s5_det_r[DET_W-1] ? DET_W'(-s5_det_r) : DET_W'(s5_det_r);

  // solution: divide by 2^FRAC_BITS toward zero, then saturate
  always_comb begin
    acc_biased = p2_acc_r + (p2_acc_r[AW-1] ? RND : '0);
    acc_sh     = acc_biased >>> FRAC_BITS;
    if (sing_r[IX_P2]) begin
      sol_nxt = '0;
    end else if (acc_sh > SOL_MAX) begin
      sol_nxt = SOL_MAX[D-1:0];
    end else if (acc_sh < SOL_MIN) begin
      sol_nxt = SOL_MIN[D-1:0];
    end else begin
      sol_nxt = acc_sh[D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s1_pa_r[j]   <= pa[j];
        s1_pb_r[j]   <= pb[j];
        s1_qa_r[j]   <= qa[j];
        s1_qb_r[j]   <= qb[j];
        s1_m0_r[j]   <= hm_r[j][0];
        s2_adj_r[j]  <= adj_t'(s1_pa_r[j]) - adj_t'(s1_pb_r[j]);
        s2_adj0_r[j] <= adj_t'(s1_qa_r[j]) - adj_t'(s1_qb_r[j]);
        s2_m0_r[j]   <= s1_m0_r[j];
        // split the row 0 cofactor so each multiply stays near D by D
        s3_plo_r[j]  <= pp_t'(s2_m0_r[j]) * pp_t'($signed({1'b0, s2_adj0_r[j][D-1:0]}));
        s3_phi_r[j]  <= pp_t'(s2_m0_r[j]) * pp_t'($signed(s2_adj0_r[j][ADJ_W-1:D]));
        s3_adj_r[j]  <= s2_adj_r[j];
        s4_term_r[j] <= (det_t'(s3_phi_r[j]) <<< D) + det_t'(s3_plo_r[j]);
        s4_adj_r[j]  <= s3_adj_r[j];
        s5_adj_r[j]  <= s4_adj_r[j];
        s6_num_r[j]  <= {adj_mag[j], {(2*FRAC_BITS){1'b0}}};
        s6_neg_r[j]  <= s5_adj_r[j][ADJ_W-1] ^ s5_det_r[DET_W-1];
        p1_inv_r[j]  <= inv_z[j];
        p1_prod_r[j] <= prod_t'(inv_z[j]) * prod_t'(rhs_r[IX_DIV][j]);
        p2_inv_r[j]  <= p1_inv_r[j];
        out_inv_r[j] <= p2_inv_r[j];
      end
      s5_det_r  <= s4_term_r[0] + s4_term_r[1] + s4_term_r[2];
      s6_den_r  <= det_mag;
      p2_acc_r  <= acc_t'(p1_prod_r[0]) + acc_t'(p1_prod_r[1]) + acc_t'(p1_prod_r[2]);
      out_sol_r <= sol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSB; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= hold_vld_r;
      for (int k = 1; k < NSB; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_r[0]  <= row_cnt_r;
      rhs_r[0]  <= hb_r;
      sing_r[0] <= 1'b0;
      for (int k = 1; k < NSB; k++) begin
        row_r[k]  <= row_r[k-1];
        rhs_r[k]  <= rhs_r[k-1];
        // singular becomes known once the determinant is summed
        if (k == IX_S6) begin
          sing_r[k] <= (s5_det_r == '0);
        end else begin
          sing_r[k] <= sing_r[k-1];
        end
      end
    end
  end

  assign out_ch.valid     = vld_r[IX_OUT];
  assign out_ch.row_index = row_r[IX_OUT];
  assign out_ch.inv_col0  = out_inv_r[0];
  assign out_ch.inv_col1  = out_inv_r[1];
  assign out_ch.inv_col2  = out_inv_r[2];
  assign out_ch.solution  = out_sol_r;
  assign out_ch.singular  = sing_r[IX_OUT];
  assign out_ch.last_row  = (row_r[IX_OUT] == LAST_ROW);

endmodule

// File: hw/rtl/lsv_checker.sv
module lsv_checker #(
  parameter int DATA_WIDTH = lsv_pkg::DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input lsv_pkg::row_t                row_index,
  input logic signed [DATA_WIDTH-1:0] inv_col0,
  input logic signed [DATA_WIDTH-1:0] inv_col1,
  input logic signed [DATA_WIDTH-1:0] inv_col2,
  input logic signed [DATA_WIDTH-1:0] solution,
  input logic                         singular,
  input logic                         last_row
);
  import lsv_pkg::*;

  row_t exp_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r <= ROW0;
    end else if (out_valid && out_ready) begin
      exp_row_r <= last_row ? ROW0 : row_index + 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({row_index, inv_col0, inv_col1, inv_col2, solution, singular, last_row}))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> row_index == exp_row_r)
    else $error("rows out of order");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> last_row == (row_index == LAST_ROW))
    else $error("last_row does not match row_index");

  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular |->
      inv_col0 == '0 && inv_col1 == '0 && inv_col2 == '0 && solution == '0)
    else $error("singular result carries nonzero values");

endmodule

bind linear_solve_3x3_unit lsv_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_lsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .row_index (out_ch.row_index),
  .inv_col0  (out_ch.inv_col0),
  .inv_col1  (out_ch.inv_col1),
  .inv_col2  (out_ch.inv_col2),
  .solution  (out_ch.solution),
  .singular  (out_ch.singular),
  .last_row  (out_ch.last_row)
);

// File: verif/linear_solve_3x3_unit_tb.sv
`timescale 1ns / 100ps

module linear_solve_3x3_unit_tb;
  import lsv_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam logic signed [159:0] QMAX = 160'sd2147483647;
  localparam logic signed [159:0] QMIN = -160'sd2147483648;

  // twelve fields in order m00..m22, rhs0..rhs2
  typedef logic [11:0][DW-1:0] system_t;

  typedef struct {
    row_t                 row_index;
    logic signed [DW-1:0] inv_col0;
    logic signed [DW-1:0] inv_col1;
    logic signed [DW-1:0] inv_col2;
    logic signed [DW-1:0] solution;
    logic                 singular;
    logic                 last_row;
  } inv_row_t;

  logic clk;
  logic rst_n;

  lsv_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  lsv_out_if #(.DATA_WIDTH(DW)) out_ch ();

  linear_solve_3x3_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  inv_row_t pending_rows[$];
  int       err_count;
  int       burst_left;
  int       gap_max;
  int       stall_pct;
  int       hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [DW-1:0] clamp_q(input logic signed [159:0] v);
    if (v > QMAX) return QMAX[DW-1:0];
    if (v < QMIN) return QMIN[DW-1:0];
    return v[DW-1:0];
  endfunction

  // exact adjugate solve, three rows queued per accepted system
  task automatic predict_inverse_rows(input system_t s);
    logic signed [159:0] a[3][3];
    logic signed [159:0] b[3];
    logic signed [159:0] adj[3][3];
    logic signed [159:0] det;
    logic signed [159:0] acc;
    logic signed [DW-1:0] inv[3];
    inv_row_t r;
    for (int i = 0; i < 3; i++) begin
      b[i] = $signed(s[9 + i]);
      for (int j = 0; j < 3; j++) a[i][j] = $signed(s[i * 3 + j]);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i][j] = a[(j+1)%3][(i+1)%3] * a[(j+2)%3][(i+2)%3]
                  - a[(j+1)%3][(i+2)%3] * a[(j+2)%3][(i+1)%3];
    det = a[0][0] * adj[0][0] + a[1][0] * adj[0][1] + a[2][0] * adj[0][2];
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        inv[j] = (det == 0) ? '0 : clamp_q((adj[i][j] <<< (2 * FB)) / det);
        acc = acc + 160'(inv[j]) * b[j];
      end
      r.row_index = row_t'(i);
      r.inv_col0  = inv[0];
      r.inv_col1  = inv[1];
      r.inv_col2  = inv[2];
      r.solution  = (det == 0) ? '0 : clamp_q(acc / 160'sd65536);
      r.singular  = (det == 0);
      r.last_row  = (row_t'(i) == LAST_ROW);
      pending_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic send_system(input system_t s);
    @(negedge clk);
    in_ch.m00  = s[0];
    in_ch.m01  = s[1];
    in_ch.m02  = s[2];
    in_ch.m10  = s[3];
    in_ch.m11  = s[4];
    in_ch.m12  = s[5];
    in_ch.m20  = s[6];
    in_ch.m21  = s[7];
    in_ch.m22  = s[8];
    in_ch.rhs0 = s[9];
    in_ch.rhs1 = s[10];
    in_ch.rhs2 = s[11];
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_inverse_rows(s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12);
      if (gap_max > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat ($urandom_range(gap_max)) @(negedge clk);
      end
    end
  endtask

  // receiver: random stall pattern plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    inv_row_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected transaction", out_ch.row_index, 0);
      end else begin
        e = pending_rows.pop_front();
        if (out_ch.row_index !== e.row_index)
          report_mismatch("row_index", out_ch.row_index, e.row_index);
        if (out_ch.inv_col0 !== e.inv_col0)
          report_mismatch("inv_col0", out_ch.inv_col0, e.inv_col0);
        if (out_ch.inv_col1 !== e.inv_col1)
          report_mismatch("inv_col1", out_ch.inv_col1, e.inv_col1);
        if (out_ch.inv_col2 !== e.inv_col2)
          report_mismatch("inv_col2", out_ch.inv_col2, e.inv_col2);
        if (out_ch.solution !== e.solution)
          report_mismatch("solution", out_ch.solution, e.solution);
        if (out_ch.singular !== e.singular)
          report_mismatch("singular", out_ch.singular, e.singular);
        if (out_ch.last_row !== e.last_row)
          report_mismatch("last_row", out_ch.last_row, e.last_row);
      end
    end
  end

  function automatic system_t diag_system(input logic [DW-1:0] d, input logic [DW-1:0] v);
    system_t s;
    s = '0;
    s[0] = d; s[4] = d; s[8] = d;
    s[9] = v; s[10] = -v; s[11] = v;
    return s;
  endfunction

  function automatic system_t fill_system(input logic [DW-1:0] v);
    system_t s;
    for (int k = 0; k < 12; k++) s[k] = v;
    return s;
  endfunction

  function automatic system_t rand_system(input int kind);
    system_t s;
    for (int k = 0; k < 12; k++) begin
      case (kind)
        0: s[k] = $urandom;
        1: s[k] = $signed($urandom_range(524288)) - 262144;
        2: s[k] = ($signed($urandom_range(4)) - 2) <<< FB;
        default: s[k] = $signed($urandom_range(64)) - 32;
      endcase
    end
    return s;
  endfunction

  task automatic test_directed;
    system_t s;
    gap_max = 0;
    stall_pct = 0;
    send_system(diag_system(32'h0001_0000, 32'h0003_0000));
    send_system(diag_system(32'h0002_0000, 32'h7FFF_FFFF));
    send_system(diag_system(32'hFFFF_0000, 32'h8000_0000));
    send_system(fill_system(32'h0000_0000));
    send_system(fill_system(32'h7FFF_FFFF));
    send_system(fill_system(32'h8000_0000));
    send_system(fill_system(32'hFFFF_FFFF));
    // tiny determinant drives the diagonal quotients into saturation
    send_system(diag_system(32'h0000_0001, 32'h0001_0000));
    send_system(diag_system(32'hFFFF_FFFF, 32'h7FFF_FFFF));
    send_system(diag_system(32'h7FFF_FFFF, 32'h8000_0000));
    send_system(diag_system(32'h8000_0000, 32'h7FFF_FFFF));
    // rank two: third row is the sum of the first two
    s = '0;
    s[0] = 32'h0001_0000; s[1] = 32'h0002_0000; s[2] = 32'h0003_0000;
    s[3] = 32'h0004_0000; s[4] = 32'h0005_0000; s[5] = 32'h0006_0000;
    s[6] = 32'h0005_0000; s[7] = 32'h0007_0000; s[8] = 32'h0009_0000;
    s[9] = 32'h0001_0000; s[10] = 32'h0001_0000; s[11] = 32'h0001_0000;
    send_system(s);
    // signed permutation matrix with mixed-sign right side
    s = '0;
    s[1] = 32'h0001_0000; s[5] = 32'hFFFF_0000; s[6] = 32'h0001_0000;
    s[9] = 32'h7FFF_FFFF; s[10] = 32'h8000_0000; s[11] = 32'h0000_8000;
    send_system(s);
    s[0] = 32'h8000_0000; s[4] = 32'h7FFF_FFFF; s[8] = 32'h0000_0001;
    send_system(s);
    s = '0;
    s[0] = 32'h0003_0000; s[1] = 32'h0001_0000; s[3] = 32'h0001_0000;
    s[4] = 32'h0002_0000; s[8] = 32'h0000_4000; s[9] = 32'hFFFF_8000;
    s[10] = 32'h0001_0000; s[11] = 32'hFFFE_0000;
    send_system(s);
  endtask

  task automatic test_random(input int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      if (k % 80 == 0) begin
        gap_max = $urandom_range(6);
        stall_pct = (k % 160 == 0) ? 0 : $urandom_range(70);
      end
      pick = $urandom_range(99);
      send_system(rand_system(pick < 30 ? 0 : pick < 75 ? 1 : pick < 90 ? 2 : 3));
    end
  endtask

  task automatic test_backpressure;
    gap_max = 0;
    stall_pct = 20;
    @(negedge clk);
    hold_cycles = 300;
    for (int k = 0; k < 30; k++) send_system(rand_system(1));
  endtask

  initial begin
    err_count = 0;
    burst_left = 0;
    gap_max = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22, in_ch.rhs0, in_ch.rhs1, in_ch.rhs2} = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(200);
    test_backpressure();
    test_random(200);

    @(negedge clk);
    in_ch.valid = 1'b0;
    stall_pct = 30;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
